@@ rtl/register_alu_flags_stack_executor_top_assert.svh @@
// Assertion macros for the register, flag and stack executor.
`ifndef REGISTER_ALU_FLAGS_STACK_EXECUTOR_TOP_ASSERT_SVH
`define REGISTER_ALU_FLAGS_STACK_EXECUTOR_TOP_ASSERT_SVH
// Assert that a condition implies a consequence in the next cycle.
`define RAFSE_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rafse check failed");
// Assert that a condition always holds.
`define RAFSE_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("rafse check failed");
`endif

@@ rtl/rafse_pkg.sv @@
// Shared types and constants of the register, flag and stack executor.
package rafse_pkg;
    localparam int DATA_W = 32;
    localparam int REG_AW = 5;
    // MULL splits the product by this power of two.
    localparam int MUL_SPLIT_DIVISOR = 16;

    typedef enum logic [4:0] {
        CMD_ADD = 5'd0, CMD_SUB = 5'd1, CMD_AND = 5'd2, CMD_XOR = 5'd3, CMD_OR = 5'd4,
        CMD_DIV = 5'd5, CMD_MULL = 5'd6, CMD_ADDI = 5'd7, CMD_SUBI = 5'd8,
        CMD_ANDI = 5'd9, CMD_XORI = 5'd10, CMD_ORI = 5'd11, CMD_MOVI = 5'd12,
        CMD_MOVR = 5'd13, CMD_SWP = 5'd14, CMD_SKIE = 5'd15, CMD_PUSH = 5'd16,
        CMD_POP = 5'd17, CMD_INPUT = 5'd18, CMD_OUTPUT = 5'd19, CMD_READREG = 5'd20
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_DIV0 = 2'd1, ST_EMPTY = 2'd2, ST_DROP = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_DIVFIX, S_POPRD, S_WRA, S_WRB, S_OUT
    } state_t;

    localparam logic [7:0] FLAG_PAR  = 8'h01;
    localparam logic [7:0] FLAG_ZERO = 8'h02;
    localparam logic [7:0] FLAG_NEG  = 8'h04;
    localparam logic [7:0] FLAG_OVF  = 8'h20;

    // Request from the sequencer to the divider.
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    // Answer of the divider.
    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quot;
        logic [DATA_W-1:0] rem;
    } div_rsp_t;

    function automatic logic [7:0] pzn(input logic [DATA_W-1:0] v, input logic ovf);
        pzn = ({7'd0, ^v} & FLAG_PAR) | ((v == '0) ? FLAG_ZERO : 8'h00)
            | (v[DATA_W-1] ? FLAG_NEG : 8'h00) | (ovf ? FLAG_OVF : 8'h00);
    endfunction
endpackage

@@ rtl/rafse_regfile.sv @@
// Register file: 32 words, one write port, one registered read port, with reset sweep.
module rafse_regfile import rafse_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              we,
    input  logic [REG_AW-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [REG_AW-1:0] raddr,
    output logic [DATA_W-1:0] rdata,
    output logic              ready
);
    logic [DATA_W-1:0] mem [32];
    logic [REG_AW:0]   clr_reg;

    assign ready = clr_reg[REG_AW];

    // After reset the sweep writes zero to one word per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (!clr_reg[REG_AW]) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!clr_reg[REG_AW]) begin
            mem[clr_reg[REG_AW-1:0]] <= '0;
        end else if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/rafse_div.sv @@
// Signed radix-2 restoring divider, one quotient bit per cycle, truncating.
module rafse_div import rafse_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic [DATA_W-1:0] q_reg, d_reg;
    logic [DATA_W:0]   r_reg;
    logic [5:0]        cnt_reg;
    logic              busy_reg, done_reg, qneg_reg, rneg_reg;
    logic [DATA_W:0]   shifted, diff;

    assign shifted = {r_reg[DATA_W-1:0], q_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
                qneg_reg <= req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
                rneg_reg <= req.dividend[DATA_W-1];
                q_reg <= req.dividend[DATA_W-1] ? -req.dividend : req.dividend;
                d_reg <= req.divisor[DATA_W-1] ? -req.divisor : req.divisor;
                r_reg <= '0;
            end else if (busy_reg) begin
                if (diff[DATA_W]) begin
                    r_reg <= shifted;
                    q_reg <= {q_reg[DATA_W-2:0], 1'b0};
                end else begin
                    r_reg <= diff;
                    q_reg <= {q_reg[DATA_W-2:0], 1'b1};
                end
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(DATA_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = qneg_reg ? -q_reg : q_reg;
    assign rsp.rem  = rneg_reg ? -r_reg[DATA_W-1:0] : r_reg[DATA_W-1:0];
endmodule

@@ rtl/register_alu_flags_stack_executor_top.sv @@
// Top level of the register, flag and stack executor.
// The block executes one instruction at a time against a 32-word register file and a stack
// memory, both synchronous RAMs with registered reads. With the result taken at once, an
// item passes from one accept to the next through the accepting cycle, two register reads,
// execute, two write-backs, the result cycle and the cycle in which the result leaves.
// MULL adds a multiply step and a successful POP a stack read step; a divide by zero or a
// pop from an empty stack skips the write-backs. DIV waits on the one-bit-per-cycle divider,
// which sets the worst case. After reset a sweep clears the register file before the first
// item is accepted. The result waits in an output register, and no new item is accepted
// until it has left.
`include "register_alu_flags_stack_executor_top_assert.svh"
module register_alu_flags_stack_executor_top import rafse_pkg::*; #(
    parameter int STACK_DEPTH       = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[4:0], dest_reg[9:5], src_a_reg[14:10], src_b_reg[19:15], immediate[51:20]
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[31:0], flags[39:32], skip_next[40], status[42:41]
    output logic [47:0] m_tdata
);
    localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SCW = $clog2(STACK_DEPTH + 1);
    localparam int MSH = $clog2(MUL_SPLIT_DIVISOR);

    state_t state_reg, state_next;
    logic [55:0]        in_reg;
    logic [4:0]         cmd;
    logic [REG_AW-1:0]  rd_a, ra_a, rb_a;
    logic [DATA_W-1:0]  imm;
    logic [DATA_W-1:0]  va_reg, vb_reg, wa_reg, wb_reg, rdat_reg;
    logic [7:0]         flags_reg;
    logic [1:0]         stat_reg;
    logic               skip_reg, wa_en_reg, wb_en_reg;
    logic [REG_AW-1:0]  wa_addr_reg, wb_addr_reg;
    logic [SAW-1:0]     top_reg;
    logic [SCW-1:0]     count_reg;
    logic               rd_phase_reg;
    logic [2*DATA_W-1:0] prod_reg;
    logic [DATA_W-1:0]  stk [STACK_DEPTH];
    logic [DATA_W-1:0]  stk_q;
    logic [SAW-1:0]     top_dec;
    logic               rf_we, rf_ready;
    logic [REG_AW-1:0]  rf_waddr, rf_raddr;
    logic [DATA_W-1:0]  rf_wdata, rf_q;
    logic [47:0]        out_reg;
    logic               ovalid_reg;
    div_req_t           dreq;
    div_rsp_t           drsp;

    assign cmd  = in_reg[4:0];
    assign rd_a = in_reg[9:5];
    assign ra_a = in_reg[14:10];
    assign rb_a = in_reg[19:15];
    assign imm  = in_reg[51:20];
    assign top_dec = (top_reg == '0) ? SAW'(STACK_DEPTH - 1) : top_reg - 1'b1;

    rafse_regfile u_rf (
        .aclk, .aresetn, .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
        .raddr(rf_raddr), .rdata(rf_q), .ready(rf_ready)
    );
    rafse_div u_div (.aclk, .aresetn, .req(dreq), .rsp(drsp));

    assign s_tready = (state_reg == S_IDLE) && rf_ready && !ovalid_reg;
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = out_reg;

    // Register read address: A first (register 0 for OUTPUT), B in the cycle after.
    assign rf_raddr = (state_reg != S_IDLE) ? rb_a :
                      (s_tdata[4:0] == CMD_OUTPUT) ? '0 : s_tdata[14:10];

    always_comb begin
        rf_we = 1'b0;
        rf_waddr = wa_addr_reg;
        rf_wdata = wa_reg;
        if (state_reg == S_WRA && wa_en_reg) begin
            rf_we = 1'b1;
        end else if (state_reg == S_WRB && wb_en_reg) begin
            rf_we = 1'b1;
            rf_waddr = wb_addr_reg;
            rf_wdata = wb_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (s_tvalid && s_tready) state_next = S_READ;
            S_READ:   if (rd_phase_reg) state_next = S_EXEC;
            S_EXEC: begin
                case (cmd)
                    CMD_DIV:  state_next = (va_reg == '0) ? S_OUT : S_DIV;
                    CMD_MULL: state_next = S_MUL;
                    CMD_POP:  state_next = (count_reg == '0) ? S_OUT : S_POPRD;
                    default:  state_next = S_WRA;
                endcase
            end
            S_MUL:    state_next = S_WRA;
            S_DIV:    if (drsp.done) state_next = S_WRA;
            S_POPRD:  state_next = S_WRA;
            S_WRA:    state_next = S_WRB;
            S_WRB:    state_next = S_OUT;
            S_OUT:    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        dreq.start    = (state_reg == S_EXEC) && (cmd == CMD_DIV) && (va_reg != '0);
        dreq.dividend = vb_reg;
        dreq.divisor  = va_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Stack memory: registered read of the entry below the top.
    always_ff @(posedge aclk) begin
        if (state_reg == S_EXEC && cmd == CMD_PUSH) begin
            stk[top_reg] <= va_reg;
        end
        stk_q <= stk[top_dec];
    end

    always_ff @(posedge aclk) begin
        logic [DATA_W-1:0] res, p, q, r;
        logic              ov;
        if (!aresetn) begin
            flags_reg <= '0;
            top_reg   <= '0;
            count_reg <= '0;
            ovalid_reg <= 1'b0;
            rd_phase_reg <= 1'b0;
        end else begin
            if (ovalid_reg && m_tready) ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && s_tready) in_reg <= s_tdata;
                    rd_phase_reg <= 1'b0;
                end
                S_READ: begin
                    if (!rd_phase_reg) va_reg <= rf_q;
                    else vb_reg <= rf_q;
                    rd_phase_reg <= 1'b1;
                end
                S_EXEC: begin
                    wa_en_reg <= 1'b0;
                    wb_en_reg <= 1'b0;
                    wa_addr_reg <= rd_a;
                    wb_addr_reg <= rb_a;
                    stat_reg <= ST_OK;
                    skip_reg <= 1'b0;
                    rdat_reg <= '0;
                    prod_reg <= $signed(vb_reg) * $signed(va_reg);
                    res = '0;
                    ov = 1'b0;
                    case (cmd)
                        CMD_ADD, CMD_SUB, CMD_ADDI, CMD_SUBI: begin
                            case (cmd)
                                CMD_ADD: begin
                                    res = va_reg + vb_reg;
                                    ov = (va_reg[31] == vb_reg[31]) && (res[31] != va_reg[31]);
                                end
                                CMD_SUB: begin
                                    res = vb_reg - va_reg;
                                    ov = (vb_reg[31] != va_reg[31]) && (res[31] != vb_reg[31]);
                                end
                                CMD_ADDI: begin
                                    res = va_reg + imm;
                                    ov = (va_reg[31] == imm[31]) && (res[31] != va_reg[31]);
                                end
                                default: begin
                                    res = va_reg - imm;
                                    ov = (va_reg[31] != imm[31]) && (res[31] != va_reg[31]);
                                end
                            endcase
                            wa_en_reg <= 1'b1; wa_reg <= res; rdat_reg <= res;
                            flags_reg <= pzn(res, ov);
                        end
                        CMD_AND, CMD_XOR, CMD_OR, CMD_ANDI, CMD_XORI, CMD_ORI: begin
                            case (cmd)
                                CMD_AND:  res = vb_reg & va_reg;
                                CMD_XOR:  res = vb_reg ^ va_reg;
                                CMD_OR:   res = vb_reg | va_reg;
                                CMD_ANDI: res = va_reg & imm;
                                CMD_XORI: res = va_reg ^ imm;
                                default:  res = va_reg | imm;
                            endcase
                            wa_en_reg <= 1'b1; wa_reg <= res; rdat_reg <= res;
                            flags_reg <= pzn(res, flags_reg[5]);
                        end
                        CMD_DIV: if (va_reg == '0) stat_reg <= ST_DIV0;
                        CMD_MOVI, CMD_INPUT: begin
                            wa_en_reg <= 1'b1; wa_reg <= imm; rdat_reg <= imm;
                            if (cmd == CMD_INPUT) wa_addr_reg <= '0;
                        end
                        CMD_MOVR: begin
                            wa_en_reg <= 1'b1; wa_reg <= va_reg; rdat_reg <= va_reg;
                        end
                        CMD_SWP: begin
                            // Writing A first then B makes B win when both name one register.
                            wa_en_reg <= 1'b1; wa_addr_reg <= ra_a; wa_reg <= vb_reg;
                            wb_en_reg <= 1'b1; wb_reg <= va_reg; rdat_reg <= va_reg;
                        end
                        CMD_SKIE: skip_reg <= (va_reg == vb_reg);
                        CMD_PUSH: begin
                            top_reg <= (top_reg == SAW'(STACK_DEPTH - 1)) ? '0 : top_reg + 1'b1;
                            if (count_reg == SCW'(STACK_DEPTH)) stat_reg <= ST_DROP;
                            else count_reg <= count_reg + 1'b1;
                            rdat_reg <= va_reg;
                        end
                        CMD_POP: if (count_reg == '0) stat_reg <= ST_EMPTY;
                        // OUTPUT fetched register 0 through port A.
                        CMD_OUTPUT, CMD_READREG: rdat_reg <= va_reg;
                        default: ;
                    endcase
                end
                S_MUL: begin
                    p = prod_reg[DATA_W-1:0];
                    ov = (prod_reg[2*DATA_W-1:DATA_W] != {DATA_W{p[DATA_W-1]}});
                    r = p & DATA_W'(MUL_SPLIT_DIVISOR - 1);
                    q = $signed(p) >>> MSH;
                    // A negative product with a remainder rounds toward zero.
                    if (p[DATA_W-1] && r != '0) begin
                        q = q + 1'b1;
                        r = r - DATA_W'(MUL_SPLIT_DIVISOR);
                    end
                    // B written first, A second so that A wins on a shared register.
                    wa_en_reg <= 1'b1; wa_addr_reg <= rb_a; wa_reg <= q;
                    wb_en_reg <= 1'b1; wb_addr_reg <= ra_a; wb_reg <= r;
                    rdat_reg <= (ra_a == rb_a) ? r : q;
                    flags_reg <= pzn(p, ov);
                end
                S_DIV: begin
                    if (drsp.done) begin
                        wa_en_reg <= 1'b1; wa_addr_reg <= rb_a; wa_reg <= drsp.quot;
                        wb_en_reg <= 1'b1; wb_addr_reg <= ra_a; wb_reg <= drsp.rem;
                        rdat_reg <= (ra_a == rb_a) ? drsp.rem : drsp.quot;
                        flags_reg <= pzn((ra_a == rb_a) ? drsp.rem : drsp.quot, flags_reg[5]);
                    end
                end
                S_POPRD: begin
                    top_reg <= top_dec;
                    count_reg <= count_reg - 1'b1;
                    wa_en_reg <= 1'b1; wa_addr_reg <= ra_a; wa_reg <= stk_q;
                    rdat_reg <= stk_q;
                end
                S_OUT: begin
                    out_reg <= {5'd0, stat_reg, skip_reg,
                                flags_reg & (FLAG_PAR | FLAG_ZERO | FLAG_NEG | FLAG_OVF), rdat_reg};
                    ovalid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    `RAFSE_ALWAYS(a_no_accept_busy, !(s_tready && state_reg != S_IDLE))
    `RAFSE_NEXT(a_out_sets_valid, state_reg == S_OUT, m_tvalid)
    `RAFSE_ALWAYS(a_count_bound, count_reg <= SCW'(STACK_DEPTH))
endmodule
